// File: sv/nrmc_pkg.sv
// Shared constants, types and helper functions for the NMEA RMC local-time parser.
// No dependencies.
`default_nettype none

package nrmc_pkg;

   localparam int LINE_POS_LIMIT  = 127;
   localparam int FRACTION_DIGITS = 4;

   localparam int LINE_POS_W = $clog2(LINE_POS_LIMIT + 1);
   localparam int FRAC_CNT_W = $clog2(FRACTION_DIGITS + 2);

   localparam int FIELD_W  = 7;
   localparam int YEAR_W   = 12;
   localparam int CHAR_W   = 8;
   localparam int ZONE_W   = 5;
   localparam int COUNT_W  = 4;
   localparam int LAT_W    = 27;
   localparam int LON_W    = 30;
   localparam int ACC_W    = LON_W;
   localparam int CALC_W   = FIELD_W + 1;

   localparam int COUNT_MAX     = 15;
   localparam int DIGITS_IN_TIME = 6;
   localparam int RMC_TAG_POS   = 5;

   localparam int ZONE_RESET = 8;

   function automatic longint pow10(input int n);
      longint p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   localparam longint LAT_MAX     = 99999999;
   localparam longint LON_MAX     = 999999999;
   localparam longint FRAC_SCALE  = pow10(FRACTION_DIGITS);
   localparam longint LAT_INT_MAX = LAT_MAX / FRAC_SCALE;
   localparam longint LON_INT_MAX = LON_MAX / FRAC_SCALE;
   localparam int     SCALE_W     = $clog2(FRAC_SCALE + 1);

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_C = 8'h43;

   // comma index that opens each field
   localparam logic [COUNT_W-1:0] FIELD_TIME   = 4'd1;
   localparam logic [COUNT_W-1:0] FIELD_STATUS = 4'd2;
   localparam logic [COUNT_W-1:0] FIELD_LAT    = 4'd3;
   localparam logic [COUNT_W-1:0] FIELD_NS     = 4'd4;
   localparam logic [COUNT_W-1:0] FIELD_LON    = 4'd5;
   localparam logic [COUNT_W-1:0] FIELD_EW     = 4'd6;
   localparam logic [COUNT_W-1:0] FIELD_DATE   = 4'd9;

   // calendar
   localparam int YEAR_BASE       = 2000;
   localparam int SEC_MAX         = 59;
   localparam int MIN_MAX         = 59;
   localparam int HOUR_MAX        = 23;
   localparam int HOURS_PER_DAY   = 24;
   localparam int DAYS_SHORT      = 30;
   localparam int DAYS_LONG       = 31;
   localparam int FEB_DAYS        = 28;
   localparam int FEB_DAYS_LEAP   = 29;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int MONTH_FEB       = 2;
   localparam int MONTH_APR       = 4;
   localparam int MONTH_JUN       = 6;
   localparam int MONTH_SEP       = 9;
   localparam int MONTH_NOV       = 11;

   typedef struct packed {
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [CHAR_W-1:0]  fix_status;
      logic [LAT_W-1:0]   latitude;
      logic [CHAR_W-1:0]  lat_hemisphere;
      logic [LON_W-1:0]   longitude;
      logic [CHAR_W-1:0]  lon_hemisphere;
   } rsp_type;

   function automatic logic [3:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = c - CHAR_ZERO;
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ? d[3:0] : 4'd0;
   endfunction

   // tens digit weighs 10, units digit weighs 1
   function automatic logic [FIELD_W-1:0] digit_weight(input logic [3:0] d, input logic units);
      logic [FIELD_W-1:0] w;
      w = FIELD_W'(d);
      return units ? w : FIELD_W'((w << 3) + (w << 1));
   endfunction

   // acc * 10 + d, optionally clamped to lim
   function automatic logic [ACC_W-1:0] accum_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0]       d,
                                                   input logic             sat,
                                                   input logic [ACC_W-1:0] lim);
      logic [ACC_W+3:0] w;
      w = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (ACC_W+4)'(d);
      if (sat && w > {4'b0, lim}) begin
         w = {4'b0, lim};
      end
      return w[ACC_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: sv/nmea_rmc_parser_local_time_core.sv
// NMEA RMC sentence parser: byte-wise field capture and local-time conversion.
// One result is registered when a newline ends a line whose byte 5 is 'C'.
// Latency: a result is valid in the cycle after its newline beat is accepted.
// Throughput: one byte per cycle; the input stalls only while a result sits
// in the output register and the output side stalls.
// Reset (sync, active high): clears line state and output valid, zone offset to 8 h.
`default_nettype none

module nmea_rmc_parser_local_time_core
   import nrmc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                csr_wr_en,
   input  wire logic [ZONE_W-1:0]   csr_zone_offset_hours,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [CHAR_W-1:0]   req_char_in,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [FIELD_W-1:0]       rsp_hour,
   output logic [FIELD_W-1:0]       rsp_minute,
   output logic [FIELD_W-1:0]       rsp_second,
   output logic [FIELD_W-1:0]       rsp_day,
   output logic [FIELD_W-1:0]       rsp_month,
   output logic [YEAR_W-1:0]        rsp_year,
   output logic [CHAR_W-1:0]        rsp_fix_status,
   output logic [LAT_W-1:0]         rsp_latitude,
   output logic [CHAR_W-1:0]        rsp_lat_hemisphere,
   output logic [LON_W-1:0]         rsp_longitude,
   output logic [CHAR_W-1:0]        rsp_lon_hemisphere
);

   logic [ZONE_W-1:0]     zone_ff;
   logic [LINE_POS_W-1:0] pos_ff,    pos_in;
   logic [COUNT_W-1:0]    comma_ff,  comma_in;
   logic [COUNT_W-1:0]    cif_ff,    cif_in;
   logic                  is_rmc_ff, is_rmc_in;
   logic [FIELD_W-1:0]    time_ff [3];
   logic [FIELD_W-1:0]    time_in [3];
   logic [FIELD_W-1:0]    date_ff [3];
   logic [FIELD_W-1:0]    date_in [3];
   logic [CHAR_W-1:0]     status_ff, status_in;
   logic [LAT_W-1:0]      lat_ff,    lat_in;
   logic [LON_W-1:0]      lon_ff,    lon_in;
   logic [CHAR_W-1:0]     ns_ff,     ns_in;
   logic [CHAR_W-1:0]     ew_ff,     ew_in;
   logic [FRAC_CNT_W-1:0] frac_ff,   frac_in;

   rsp_type               rsp_ff,    rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  is_newline;
   logic                  is_comma;
   logic                  is_dot;
   logic [3:0]            dig;
   logic [1:0]            slot;

   logic [FRAC_CNT_W-1:0] taken;
   logic [SCALE_W-1:0]    scale;
   logic [LAT_W-1:0]      lat_fin;
   logic [LON_W-1:0]      lon_fin;
   logic                  in_lat, in_lon;
   logic [ACC_W-1:0]      acc_cur, acc_lim, acc_new;

   logic [CALC_W-1:0]     hr_v, mi_v, se_v, dy_v, mo_v;
   logic [YEAR_W-1:0]     yr_v;
   logic                  emit;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign is_newline = req_char_in == CHAR_NEWLINE;
   assign is_comma   = req_char_in == CHAR_COMMA;
   assign is_dot     = req_char_in == CHAR_DOT;
   assign dig        = digit_of(req_char_in);
   assign slot       = cif_ff[2:1];
   assign emit       = accept && is_newline && is_rmc_ff;

   // closing a lat/lon field pads the missing fraction digits
   always_comb begin
      taken = (frac_ff == '0) ? '0 : frac_ff - FRAC_CNT_W'(1);
      scale = SCALE_W'(1);
      for (int k = 0; k <= FRACTION_DIGITS; k++) begin
         if (taken == FRAC_CNT_W'(k)) begin
            scale = SCALE_W'(pow10(FRACTION_DIGITS - k));
         end
      end
      lat_fin = LAT_W'(lat_ff * scale);
      lon_fin = LON_W'(lon_ff * scale);
   end

   // one digit into the active lat/lon accumulator
   always_comb begin
      in_lat  = comma_ff == FIELD_LAT;
      in_lon  = comma_ff == FIELD_LON;
      acc_cur = in_lat ? ACC_W'(lat_ff) : lon_ff;
      acc_lim = in_lat ? ACC_W'(LAT_INT_MAX) : ACC_W'(LON_INT_MAX);
      acc_new = accum_digit(acc_cur, dig, frac_ff == '0, acc_lim);
   end

   always_comb begin
      pos_in    = pos_ff;
      comma_in  = comma_ff;
      cif_in    = cif_ff;
      is_rmc_in = is_rmc_ff;
      time_in   = time_ff;
      date_in   = date_ff;
      status_in = status_ff;
      lat_in    = lat_ff;
      lon_in    = lon_ff;
      ns_in     = ns_ff;
      ew_in     = ew_ff;
      frac_in   = frac_ff;

      if (accept) begin
         if (is_newline) begin
            pos_in    = '0;
            comma_in  = '0;
            cif_in    = '0;
            is_rmc_in = 1'b0;
            for (int i = 0; i < 3; i++) begin
               time_in[i] = '0;
               date_in[i] = '0;
            end
            status_in = '0;
            lat_in    = '0;
            lon_in    = '0;
            ns_in     = '0;
            ew_in     = '0;
            frac_in   = '0;
         end else begin
            if (pos_ff == LINE_POS_W'(RMC_TAG_POS)) begin
               is_rmc_in = req_char_in == CHAR_UPPER_C;
            end
            if (pos_ff < LINE_POS_W'(LINE_POS_LIMIT)) begin
               pos_in = pos_ff + LINE_POS_W'(1);
            end

            // first byte of a field, a comma when the field is empty
            if (cif_ff == '0) begin
               if (comma_ff == FIELD_STATUS) begin
                  status_in = req_char_in;
               end else if (comma_ff == FIELD_NS) begin
                  ns_in = req_char_in;
               end else if (comma_ff == FIELD_EW) begin
                  ew_in = req_char_in;
               end
            end

            if (is_comma) begin
               if (in_lat) begin
                  lat_in = lat_fin;
               end else if (in_lon) begin
                  lon_in = lon_fin;
               end
               if (comma_ff < COUNT_W'(COUNT_MAX)) begin
                  comma_in = comma_ff + COUNT_W'(1);
               end
               cif_in  = '0;
               frac_in = '0;
            end else begin
               if (comma_ff == FIELD_TIME && cif_ff < COUNT_W'(DIGITS_IN_TIME)) begin
                  for (int i = 0; i < 3; i++) begin
                     if (slot == 2'(i)) begin
                        time_in[i] = time_ff[i] + digit_weight(dig, cif_ff[0]);
                     end
                  end
               end else if (comma_ff == FIELD_DATE &&
                            cif_ff < COUNT_W'(DIGITS_IN_TIME)) begin
                  for (int i = 0; i < 3; i++) begin
                     if (slot == 2'(i)) begin
                        date_in[i] = date_ff[i] + digit_weight(dig, cif_ff[0]);
                     end
                  end
               end else if (in_lat || in_lon) begin
                  if (frac_ff == '0) begin
                     if (is_dot) begin
                        frac_in = FRAC_CNT_W'(1);
                     end else if (in_lat) begin
                        lat_in = LAT_W'(acc_new);
                     end else begin
                        lon_in = acc_new;
                     end
                  end else if (frac_ff <= FRAC_CNT_W'(FRACTION_DIGITS)) begin
                     frac_in = frac_ff + FRAC_CNT_W'(1);
                     if (in_lat) begin
                        lat_in = LAT_W'(acc_new);
                     end else begin
                        lon_in = acc_new;
                     end
                  end
               end
               if (cif_ff < COUNT_W'(COUNT_MAX)) begin
                  cif_in = cif_ff + COUNT_W'(1);
               end
            end
         end
      end
   end

   // time and date adjustment for the line that ends now
   always_comb begin
      hr_v = CALC_W'(time_ff[0]);
      mi_v = CALC_W'(time_ff[1]);
      se_v = CALC_W'(time_ff[2]) + CALC_W'(1);
      dy_v = CALC_W'(date_ff[0]);
      mo_v = CALC_W'(date_ff[1]);
      yr_v = YEAR_W'(date_ff[2]) + YEAR_W'(YEAR_BASE);

      if (se_v > SEC_MAX) begin
         se_v = '0;
         mi_v = mi_v + CALC_W'(1);
         if (mi_v > MIN_MAX) begin
            mi_v = '0;
            hr_v = hr_v + CALC_W'(1);
         end
      end
      hr_v = hr_v + CALC_W'(zone_ff);
      if (hr_v > HOUR_MAX) begin
         hr_v = hr_v - CALC_W'(HOURS_PER_DAY);
         dy_v = dy_v + CALC_W'(1);
         if (mo_v == MONTH_FEB || mo_v == MONTH_APR || mo_v == MONTH_JUN ||
             mo_v == MONTH_SEP || mo_v == MONTH_NOV) begin
            if (dy_v > DAYS_SHORT) begin
               dy_v = CALC_W'(1);
               mo_v = mo_v + CALC_W'(1);
            end
         end else if (dy_v > DAYS_LONG) begin
            dy_v = CALC_W'(1);
            mo_v = mo_v + CALC_W'(1);
         end
         // leap year when year mod 4 is zero
         if (yr_v[1:0] == 2'b00) begin
            if (dy_v > FEB_DAYS_LEAP && mo_v == MONTH_FEB) begin
               dy_v = CALC_W'(1);
               mo_v = mo_v + CALC_W'(1);
            end
         end else if (dy_v > FEB_DAYS && mo_v == MONTH_FEB) begin
            dy_v = CALC_W'(1);
            mo_v = mo_v + CALC_W'(1);
         end
         if (mo_v > MONTHS_PER_YEAR) begin
            mo_v = mo_v - CALC_W'(MONTHS_PER_YEAR);
            yr_v = yr_v + YEAR_W'(1);
         end
      end

      rsp_in.hour           = hr_v[FIELD_W-1:0];
      rsp_in.minute         = mi_v[FIELD_W-1:0];
      rsp_in.second         = se_v[FIELD_W-1:0];
      rsp_in.day            = dy_v[FIELD_W-1:0];
      rsp_in.month          = mo_v[FIELD_W-1:0];
      rsp_in.year           = yr_v;
      rsp_in.fix_status     = status_ff;
      rsp_in.latitude       = in_lat ? lat_fin : lat_ff;
      rsp_in.lat_hemisphere = ns_ff;
      rsp_in.longitude      = in_lon ? lon_fin : lon_ff;
      rsp_in.lon_hemisphere = ew_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff      <= ZONE_W'(ZONE_RESET);
         pos_ff       <= '0;
         comma_ff     <= '0;
         cif_ff       <= '0;
         is_rmc_ff    <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            time_ff[i] <= '0;
            date_ff[i] <= '0;
         end
         status_ff    <= '0;
         lat_ff       <= '0;
         lon_ff       <= '0;
         ns_ff        <= '0;
         ew_ff        <= '0;
         frac_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            zone_ff <= csr_zone_offset_hours;
         end
         pos_ff       <= pos_in;
         comma_ff     <= comma_in;
         cif_ff       <= cif_in;
         is_rmc_ff    <= is_rmc_in;
         time_ff      <= time_in;
         date_ff      <= date_in;
         status_ff    <= status_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         ns_ff        <= ns_in;
         ew_ff        <= ew_in;
         frac_ff      <= frac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hour           = rsp_ff.hour;
   assign rsp_minute         = rsp_ff.minute;
   assign rsp_second         = rsp_ff.second;
   assign rsp_day            = rsp_ff.day;
   assign rsp_month          = rsp_ff.month;
   assign rsp_year           = rsp_ff.year;
   assign rsp_fix_status     = rsp_ff.fix_status;
   assign rsp_latitude       = rsp_ff.latitude;
   assign rsp_lat_hemisphere = rsp_ff.lat_hemisphere;
   assign rsp_longitude      = rsp_ff.longitude;
   assign rsp_lon_hemisphere = rsp_ff.lon_hemisphere;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty output register");

   a_newline_clears_line: assert property (@(posedge clock) disable iff (reset)
      (accept && is_newline) |=> (pos_ff == '0 && comma_ff == '0 && !is_rmc_ff))
      else $error("line state not cleared after newline");

   a_rmc_line_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && is_newline && is_rmc_ff) |=> rsp_valid_ff)
      else $error("RMC line ended without a result");

   a_frac_bounded: assert property (@(posedge clock) disable iff (reset)
      frac_ff <= FRAC_CNT_W'(FRACTION_DIGITS + 1))
      else $error("fraction digit count out of range");

   a_result_leaves_on_take: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(!rsp_stall))
      else $error("result dropped while stalled");

endmodule

`default_nettype wire
